FILE: sv/mstm_pkg.sv
// package for the multi-slot countdown timer
// slot modes, request codes, field widths and parameter defaults; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mstm_pkg;

  localparam int TIME_W        = 23;
  localparam int TICK_W        = 10;
  localparam int NUM_SLOTS_DEF = 4;
  localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(1);

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_PAUSE = 2'd2,
    MODE_RING  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REQ_TICK      = 2'd0,
    REQ_PRIMARY   = 2'd1,
    REQ_SECONDARY = 2'd2,
    REQ_LOAD      = 2'd3
  } req_t;

endpackage

`default_nettype wire

FILE: sv/multi_slot_countdown_timer_top.sv
// top level of the multi-slot countdown timer: slot state in two memories
// with a read-modify-write sequencer; depends on mstm_pkg
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   in_* is a stream of requests: in_tuser carries the request kind (tick,
//   primary, secondary, load), in_tdata the addressed slot and a preset.
//   Every request gives exactly one result transfer on out_*, which reports
//   the addressed slot after the request and the bank-wide status masks.
//   cfg_we / cfg_wdata write tick_ms; write it only while the block is idle (not enforced by the block).
// Sequence
//   a command is read, applied, reported and output in turn (a slot outside
//   the bank goes straight to report), a tick walks the slot memory one entry
//   per read and write state pair; one request is in work at a time.
// Reset
//   rst_n low for one cycle: all slots idle, times zero, tick_ms 1; the
//   memories are not swept, per-entry valid bits make unwritten entries
//   read as zero.
// Stalls
//   a result waits in the output register while out_tready is low; the next
//   request is still taken and runs until its own result needs the register.
module multi_slot_countdown_timer_top #(
  parameter int NUM_SLOTS = mstm_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [mstm_pkg::TICK_W-1:0] cfg_wdata,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [31:0]                in_tdata,   // slot[1:0], preset_ms[24:2]
  input  wire logic [1:0]                 in_tuser,   // req_type[1:0]
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // slot_state[1:0], remaining_ms[24:2], running_mask[28:25], ringing_mask[32:29],
  // alarm_on[33], alarm_slot[35:34]
  output logic [39:0]                     out_tdata
);
  import mstm_pkg::*;

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int MW = TIME_W + 2;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_CRD  = 7'b0000010,
    ST_CMD  = 7'b0000100,
    ST_TRD  = 7'b0001000,
    ST_TWR  = 7'b0010000,
    ST_RPT  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  state_t              st_r, st_nxt;
  logic [TICK_W-1:0]   tick_r;
  req_t                req_r;
  logic [1:0]          slot_r;
  logic [TIME_W-1:0]   val_r;
  logic [SW-1:0]       idx_r, idx_nxt;
  logic                out_valid_r;
  logic [39:0]         out_data_r;

  logic [MW-1:0]       slot_mem [NUM_SLOTS];
  logic [TIME_W-1:0]   pre_mem  [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] slot_vld_r, pre_vld_r;
  logic [NUM_SLOTS-1:0] run_r, ring_r;
  logic [MW-1:0]       slot_q;
  logic [TIME_W-1:0]   pre_q;
  logic                slot_qv, pre_qv;

  logic                slot_ok;
  logic [SW-1:0]       sidx, rd_addr, wa;
  mode_t               cur_mode, nxt_mode;
  logic [TIME_W-1:0]   cur_rem, cur_pre, nxt_rem, tick_ext;
  logic                slot_we, pre_we;
  logic                accept, out_load;

  logic [NUM_SLOTS+3:0] run_ext, ring_ext;
  logic                alarm_on;
  logic [1:0]          alarm_slot;
  logic [39:0]         res_data;

  assign slot_ok  = 32'(slot_r) < NUM_SLOTS;
  assign sidx     = SW'(slot_r);
  assign rd_addr  = (st_r == ST_TRD) ? idx_r : sidx;
  assign wa       = (st_r == ST_TWR) ? idx_r : sidx;
  assign cur_mode = slot_qv ? mode_t'(slot_q[TIME_W +: 2]) : MODE_IDLE;
  assign cur_rem  = slot_qv ? slot_q[TIME_W-1:0] : '0;
  assign cur_pre  = pre_qv ? pre_q : '0;
  assign tick_ext = TIME_W'(tick_r);

  assign in_tready  = (st_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_load   = (st_r == ST_OUT) && (!out_valid_r || out_tready);

  // memories
  always_ff @(posedge clk) begin
    slot_q <= slot_mem[rd_addr];
    pre_q  <= pre_mem[sidx];
    if (slot_we) begin
      slot_mem[wa] <= {nxt_mode, nxt_rem};
    end
    if (pre_we) begin
      pre_mem[sidx] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= '0;
      pre_vld_r  <= '0;
      run_r      <= '0;
      ring_r     <= '0;
      slot_qv    <= 1'b0;
      pre_qv     <= 1'b0;
    end else begin
      slot_qv <= slot_vld_r[rd_addr];
      pre_qv  <= pre_vld_r[sidx];
      if (slot_we) begin
        slot_vld_r[wa] <= 1'b1;
        run_r[wa]      <= (nxt_mode == MODE_RUN);
        ring_r[wa]     <= (nxt_mode == MODE_RING);
      end
      if (pre_we) begin
        pre_vld_r[sidx] <= 1'b1;
      end
    end
  end

  // slot update
  always_comb begin
    nxt_mode = cur_mode;
    nxt_rem  = cur_rem;
    slot_we  = 1'b0;
    pre_we   = 1'b0;
    if (st_r == ST_TWR) begin
      if (cur_mode == MODE_RUN) begin
        slot_we  = 1'b1;
        nxt_rem  = (cur_rem > tick_ext) ? cur_rem - tick_ext : '0;
        nxt_mode = (nxt_rem == '0) ? MODE_RING : MODE_RUN;
      end
    end else if (st_r == ST_CMD) begin
      unique case (req_r)
        REQ_PRIMARY: begin
          slot_we = 1'b1;
          unique case (cur_mode)
            MODE_IDLE, MODE_PAUSE: nxt_mode = (cur_rem != '0) ? MODE_RUN : MODE_IDLE;
            MODE_RUN:              nxt_mode = MODE_PAUSE;
            MODE_RING: begin
              nxt_mode = MODE_IDLE;
              nxt_rem  = cur_pre;
            end
          endcase
        end
        REQ_SECONDARY: begin
          if (cur_mode != MODE_IDLE) begin
            slot_we  = 1'b1;
            nxt_mode = MODE_IDLE;
            nxt_rem  = cur_pre;
          end
        end
        REQ_LOAD: begin
          slot_we  = 1'b1;
          pre_we   = 1'b1;
          nxt_rem  = val_r;
          nxt_mode = (cur_mode == MODE_PAUSE) ? MODE_PAUSE : MODE_IDLE;
        end
        REQ_TICK: begin
        end
      endcase
    end
  end

  // sequencer
  always_comb begin
    st_nxt  = st_r;
    idx_nxt = idx_r;
    unique case (st_r)
      ST_IDLE: begin
        if (accept) begin
          idx_nxt = '0;
          if (req_t'(in_tuser) == REQ_TICK) begin
            st_nxt = ST_TRD;
          end else if (32'(in_tdata[1:0]) < NUM_SLOTS) begin
            st_nxt = ST_CRD;
          end else begin
            st_nxt = ST_RPT;
          end
        end
      end
      ST_CRD: st_nxt = ST_CMD;
      ST_CMD: st_nxt = ST_RPT;
      ST_TRD: st_nxt = ST_TWR;
      ST_TWR: begin
        if (idx_r == SW'(NUM_SLOTS - 1)) begin
          st_nxt = ST_RPT;
        end else begin
          idx_nxt = idx_r + 1'b1;
          st_nxt  = ST_TRD;
        end
      end
      ST_RPT: st_nxt = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // status and result
  assign run_ext  = {4'b0, run_r};
  assign ring_ext = {4'b0, ring_r};
  assign alarm_on = |ring_r;

  always_comb begin
    alarm_slot = 2'd0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (ring_r[i]) begin
        alarm_slot = 2'(i);
      end
    end
  end

  assign res_data = {4'b0, alarm_slot, alarm_on, ring_ext[3:0], run_ext[3:0],
                     slot_ok ? cur_rem : {TIME_W{1'b0}},
                     slot_ok ? cur_mode : MODE_IDLE};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      tick_r      <= TICK_RESET;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      st_r  <= st_nxt;
      idx_r <= idx_nxt;
      if (cfg_we) begin
        tick_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r  <= req_t'(in_tuser);
      slot_r <= in_tdata[1:0];
      val_r  <= in_tdata[24:2];
    end
    if (out_load) begin
      out_data_r <= res_data;
    end
  end

endmodule

`default_nettype wire
